/* rtl/ewrc_pkg.sv */
package ewrc_pkg;

    // Operation codes carried by each request
    typedef enum logic [1:0] {
        OP_SEND     = 2'd0,
        OP_FEEDBACK = 2'd1,
        OP_RECEIVE  = 2'd2,
        OP_OPEN     = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLOT_SHIFT = 2'd0;
    localparam logic [1:0] CFG_BYTE_LIMIT = 2'd1;
    localparam logic [1:0] CFG_INCREASE   = 2'd2;

    // Configuration reset values
    localparam logic [5:0]  CFG_SLOT_SHIFT_RST = 6'd24;
    localparam logic [31:0] CFG_BYTE_LIMIT_RST = 32'd65536;
    localparam logic [31:0] CFG_INCREASE_RST   = 32'd65536;

    // Window control constants
    localparam int          WIN_LOG    = 5;
    localparam int          DEC_SHIFT  = WIN_LOG + 8;
    localparam logic [31:0] MIN_PKTS   = 32'd8;
    localparam logic [31:0] MAX_PKTS   = 32'd64;
    localparam logic [5:0]  TXC_MAX    = 6'd33;
    localparam logic [5:0]  TXC_HOLD   = 6'(1 << WIN_LOG);
    localparam logic [15:0] DEC_LIMIT  = 16'(1 << DEC_SHIFT);
    localparam logic [2:0]  UPD_MASK   = 3'((1 << (WIN_LOG - 3)) - 1);

    typedef struct packed {
        op_t         operation;
        logic [63:0] time_ns;
        logic [15:0] byte_length;
        logic [7:0]  ecn_mark;
        logic [15:0] feedback_level;
    } req_item_t;

    typedef struct packed {
        logic [62:0] wait_ns;
        logic [15:0] upstream_level;
        logic        send_feedback;
    } res_item_t;

endpackage

/* rtl/ecn_window_rate_controller_top.sv */
// Channel   | Handshake                | Payload
// ----------+--------------------------+----------------------------
// request   | req_valid / req_ready    | req_data  (ewrc_pkg::req_item_t)
// result    | res_valid / res_ready    | res_data  (ewrc_pkg::res_item_t)
// config    | cfg_write                | cfg_index, cfg_data
//
// One request per cycle while the result is taken; an accepted request passes through
// the input register, then the whole context update into the result register.
// Back-to-back requests see each other's context update with no bubble.
// Reset loads the configuration defaults and an opened context at time zero.
// A stalled result holds the result register; the input register drains into it
// once the result is taken, and req_ready follows that.
module ecn_window_rate_controller_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ewrc_pkg::req_item_t req_data,
    output logic                res_valid,
    input  logic                res_ready,
    output ewrc_pkg::res_item_t res_data,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import ewrc_pkg::*;

    // Configuration registers
    logic [5:0]  init_shift_reg;
    logic [31:0] init_limit_reg;
    logic [31:0] init_inc_reg;

    // Flow context
    logic [15:0] rx_level_reg,       rx_level_next;
    logic [2:0]  rx_count_reg,       rx_count_next;
    logic [15:0] tx_level_reg,       tx_level_next;
    logic [5:0]  tx_count_reg,       tx_count_next;
    logic [63:0] window_bytes_reg,   window_bytes_next;
    logic [31:0] window_packets_reg, window_packets_next;
    logic [63:0] byte_limit_reg,     byte_limit_next;
    logic        avoid_reg,          avoid_next;
    logic [5:0]  slot_shift_reg,     slot_shift_next;
    logic [63:0] increase_reg,       increase_next;
    logic [63:0] slot_index_reg,     slot_index_next;

    // Pipeline registers
    logic        s1_valid_reg;
    req_item_t   s1_reg;
    logic        res_valid_reg;
    res_item_t   res_data_reg,       res_data_next;

    logic        s1_move;

    // Saturating left shift
    function automatic logic [63:0] sat_shl(input logic [63:0] v, input logic [5:0] f);
        logic [63:0] s;
        s = v << f;
        return ((s >> f) != v) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    // Handshake
    assign s1_move   = s1_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !s1_valid_reg || s1_move;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_shift_reg <= CFG_SLOT_SHIFT_RST;
            init_limit_reg <= CFG_BYTE_LIMIT_RST;
            init_inc_reg   <= CFG_INCREASE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SLOT_SHIFT: init_shift_reg <= cfg_data[5:0];
                CFG_BYTE_LIMIT: init_limit_reg <= cfg_data;
                CFG_INCREASE:   init_inc_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Context update and result
    always_comb
    begin
        logic [63:0] t;
        logic [63:0] slot;
        logic [63:0] gap;
        logic [63:0] bl;
        logic [63:0] inc;
        logic [63:0] si;
        logic [63:0] wb;
        logic [63:0] dec;
        logic [63:0] d;
        logic [47:0] hi_prod;
        logic [47:0] lo_prod;
        logic [31:0] wp;
        logic [15:0] txl;
        logic [5:0]  txc;
        logic [5:0]  ss;
        logic [5:0]  f;
        logic [5:0]  room;
        logic [5:0]  down_f0;
        logic [5:0]  up_f0;
        logic [16:0] rx_v;
        logic        carry;

        rx_level_next       = rx_level_reg;
        rx_count_next       = rx_count_reg;
        tx_level_next       = tx_level_reg;
        tx_count_next       = tx_count_reg;
        window_bytes_next   = window_bytes_reg;
        window_packets_next = window_packets_reg;
        byte_limit_next     = byte_limit_reg;
        avoid_next          = avoid_reg;
        slot_shift_next     = slot_shift_reg;
        increase_next       = increase_reg;
        slot_index_next     = slot_index_reg;
        res_data_next       = '0;

        t       = s1_reg.time_ns;
        slot    = t >> slot_shift_reg;
        gap     = slot_index_reg - slot;
        txc     = (tx_count_reg < TXC_MAX) ? tx_count_reg + 6'd1 : tx_count_reg;
        wp      = (window_packets_reg != 32'hFFFF_FFFF) ? window_packets_reg + 32'd1
                                                         : window_packets_reg;
        wb      = window_bytes_reg + 64'(s1_reg.byte_length);
        txl     = (txc > TXC_HOLD) ? 16'd0 : tx_level_reg;
        bl      = byte_limit_reg;
        inc     = increase_reg;
        si      = slot_index_reg;
        ss      = slot_shift_reg;
        carry   = 1'b0;
        f       = '0;
        room    = 6'd63 - slot_shift_reg;
        d       = '0;
        rx_v    = '0;

        // Multiplicative decrease: limit * level >> DEC_SHIFT in two halves
        hi_prod = 48'(byte_limit_reg[63:32]) * 48'(txl);
        lo_prod = 48'(byte_limit_reg[31:0]) * 48'(txl);
        dec     = (64'(hi_prod) << (32 - DEC_SHIFT)) + 64'(lo_prod >> DEC_SHIFT);

        // Halvings needed to bring the packet count down to MAX_PKTS:
        // one past the highest shift that still leaves it above
        down_f0 = '0;
        for (int k = 0; k < 32; k++)
        begin
            if ((wp >> k) > MAX_PKTS)
                down_f0 = 6'(k + 1);
        end

        // Doublings (at most three) toward MIN_PKTS
        if (wp < 32'd2)
            up_f0 = 6'd3;
        else if (wp < 32'd4)
            up_f0 = 6'd2;
        else
            up_f0 = 6'd1;

        case (s1_reg.operation)
            OP_SEND:
            begin
                // Slot boundary (wrapping difference negative): adjust limit,
                // then rescale the slot
                if (gap[63])
                begin
                    si = slot;
                    if (!avoid_reg)
                    begin
                        if (wb > bl)
                            bl = sat_shl(bl, 6'd1);
                    end
                    else if (txl != 16'd0)
                    begin
                        if (txl >= DEC_LIMIT)
                            bl = '0;
                        else
                            bl = bl - dec;
                    end
                    else if (wb > bl)
                    begin
                        bl = (bl + inc < bl) ? 64'hFFFF_FFFF_FFFF_FFFF : bl + inc;
                    end

                    if (wp < MIN_PKTS)
                    begin
                        f = (up_f0 > room) ? room : up_f0;
                        if (f != 6'd0)
                        begin
                            ss = slot_shift_reg + f;
                            si = slot >> f;
                            if ((si & ((64'd1 << f) - 64'd1)) == 64'd0)
                            begin
                                carry = 1'b1;
                                si    = si + 64'd1;
                            end
                            bl  = sat_shl(bl, f);
                            inc = sat_shl(inc, f);
                        end
                    end
                    else if (wp > MAX_PKTS)
                    begin
                        f   = (down_f0 > slot_shift_reg) ? slot_shift_reg : down_f0;
                        ss  = slot_shift_reg - f;
                        si  = slot << f;
                        bl  = bl >> f;
                        inc = inc >> f;
                    end

                    if (!carry)
                    begin
                        wb = '0;
                        wp = '0;
                    end
                end

                // Pacing wait until the end of the current slot
                if (wb > bl)
                begin
                    d = ((si + 64'd1) << ss) - t;
                    if (!d[63])
                        res_data_next.wait_ns = d[62:0];
                end

                tx_count_next       = txc;
                tx_level_next       = txl;
                window_packets_next = wp;
                window_bytes_next   = wb;
                byte_limit_next     = bl;
                increase_next       = inc;
                slot_shift_next     = ss;
                slot_index_next     = si;
            end

            OP_FEEDBACK:
            begin
                tx_level_next = s1_reg.feedback_level;
                tx_count_next = '0;
                avoid_next    = 1'b1;
            end

            OP_RECEIVE:
            begin
                // Upstream level tracking
                if (rx_level_reg == 16'd0 && s1_reg.ecn_mark == 8'd0)
                begin
                    res_data_next.send_feedback = 1'b0;
                end
                else if (s1_reg.ecn_mark == 8'd0)
                begin
                    rx_level_next = rx_level_reg >> 2;
                    res_data_next.send_feedback = (rx_level_next == 16'd0);
                end
                else if (rx_level_reg == 16'd0)
                begin
                    rx_level_next = 16'(s1_reg.ecn_mark);
                    rx_count_next = '0;
                    res_data_next.send_feedback = 1'b1;
                end
                else
                begin
                    rx_v = 17'(rx_level_reg) - 17'(rx_level_reg >> WIN_LOG)
                         + 17'(s1_reg.ecn_mark);
                    rx_level_next = rx_v[15:0];
                    res_data_next.send_feedback = ((rx_count_reg & UPD_MASK) == 3'd1);
                    rx_count_next = rx_count_reg + 3'd1;
                end
                res_data_next.upstream_level = rx_level_next;
            end

            default:
            begin
                // Open: fresh context from the configuration
                rx_level_next       = '0;
                rx_count_next       = '0;
                tx_level_next       = '0;
                tx_count_next       = '0;
                window_bytes_next   = '0;
                window_packets_next = '0;
                avoid_next          = 1'b0;
                slot_shift_next     = init_shift_reg;
                byte_limit_next     = 64'(init_limit_reg);
                increase_next       = 64'(init_inc_reg);
                slot_index_next     = t >> init_shift_reg;
            end
        endcase
    end

    // Context registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_level_reg       <= '0;
            rx_count_reg       <= '0;
            tx_level_reg       <= '0;
            tx_count_reg       <= '0;
            window_bytes_reg   <= '0;
            window_packets_reg <= '0;
            byte_limit_reg     <= 64'(CFG_BYTE_LIMIT_RST);
            avoid_reg          <= 1'b0;
            slot_shift_reg     <= CFG_SLOT_SHIFT_RST;
            increase_reg       <= 64'(CFG_INCREASE_RST);
            slot_index_reg     <= '0;
        end
        else if (s1_move)
        begin
            rx_level_reg       <= rx_level_next;
            rx_count_reg       <= rx_count_next;
            tx_level_reg       <= tx_level_next;
            tx_count_reg       <= tx_count_next;
            window_bytes_reg   <= window_bytes_next;
            window_packets_reg <= window_packets_next;
            byte_limit_reg     <= byte_limit_next;
            avoid_reg          <= avoid_next;
            slot_shift_reg     <= slot_shift_next;
            increase_reg       <= increase_next;
            slot_index_reg     <= slot_index_next;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (s1_move)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            s1_reg <= req_data;
        if (s1_move)
            res_data_reg <= res_data_next;
    end

    // Checks
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("input stage lost or changed a stalled request");

    a_wait_send_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_reg.operation != OP_SEND) |=>
        (res_valid_reg && res_data_reg.wait_ns == 63'd0))
        else $error("nonzero wait on a non-send request");

    a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_reg.operation == OP_OPEN) |=>
        (rx_count_reg == 3'd0 && window_packets_reg == 32'd0 && !avoid_reg))
        else $error("open did not clear the context");

    a_txc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_count_reg <= TXC_MAX)
        else $error("tx count beyond its saturation point");

endmodule
